>>> hw/rtl/u2c_pkg.sv
// Shared types, constants and lead-byte classification for the UTF-8 decoder.
`default_nettype none

package u2c_pkg;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int CNT_W   = 3;

    // Replacement character and shortest-form limits
    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [20:0] MIN_TWO   = 21'h000080;
    localparam logic [20:0] MIN_THREE = 21'h000800;
    localparam logic [20:0] MIN_FOUR  = 21'h010000;

    // Trail byte counts announced by a lead byte
    localparam logic [2:0] TRAIL_NONE  = 3'd0;
    localparam logic [2:0] TRAIL_ONE   = 3'd1;
    localparam logic [2:0] TRAIL_TWO   = 3'd2;
    localparam logic [2:0] TRAIL_THREE = 3'd3;
    localparam logic [2:0] TRAIL_FOUR  = 3'd4;
    localparam logic [2:0] TRAIL_FIVE  = 3'd5;

    // Byte kinds seen while no sequence is pending
    localparam logic [1:0] KIND_ASCII = 2'd0;
    localparam logic [1:0] KIND_LEAD  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] trail;
        logic [4:0] bits;
    } u2c_lead_t;

    // One result record as it sits in the queue
    typedef struct packed {
        logic [20:0] value;
        logic [2:0]  used;
        logic        repl;
        logic        last;
    } u2c_rec_t;

    // Up to two records pushed per accepted byte
    typedef struct packed {
        logic     valid0;
        logic     valid1;
        u2c_rec_t rec0;
        u2c_rec_t rec1;
    } u2c_push_t;

    function automatic u2c_lead_t u2c_classify(input logic [7:0] b);
        u2c_lead_t r;
        r.kind  = KIND_BAD;
        r.trail = TRAIL_NONE;
        r.bits  = 5'd0;
        case (b) inside
            [8'h00:8'h7F]: r.kind = KIND_ASCII;
            [8'hC0:8'hDF]: begin
                r.kind  = KIND_LEAD;
                r.trail = TRAIL_ONE;
                r.bits  = b[4:0];
            end
            [8'hE0:8'hEF]: begin
                r.kind  = KIND_LEAD;
                r.trail = TRAIL_TWO;
                r.bits  = {1'b0, b[3:0]};
            end
            [8'hF0:8'hF7]: begin
                r.kind  = KIND_LEAD;
                r.trail = TRAIL_THREE;
                r.bits  = {2'b0, b[2:0]};
            end
            [8'hF8:8'hFB]: begin
                r.kind  = KIND_LEAD;
                r.trail = TRAIL_FOUR;
                r.bits  = {3'b0, b[1:0]};
            end
            [8'hFC:8'hFD]: begin
                r.kind  = KIND_LEAD;
                r.trail = TRAIL_FIVE;
                r.bits  = {4'b0, b[0]};
            end
            default: r.kind = KIND_BAD;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/u2c_front.sv
// Front end: accepts bytes, tracks the pending sequence and forms result records.
`default_nettype none

module u2c_front
    import u2c_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_eob,
    output u2c_push_t       push
);

    logic [20:0] pv_reg, pv_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  total_reg, total_next;
    logic [2:0]  taken_reg, taken_next;

    logic        accept;
    u2c_lead_t   lead;
    logic        is_cont;
    logic [20:0] pv_shift;
    logic [2:0]  taken_inc;
    logic        bad;
    logic        lead_emits;
    u2c_rec_t    lead_rec;

    assign accept = in_valid & in_ready;

    // Decode the byte against the pending sequence
    always_comb begin
        lead      = u2c_classify(in_byte);
        is_cont   = (in_byte[7:6] == 2'b10);
        pv_shift  = {pv_reg[14:0], in_byte[5:0]};
        taken_inc = taken_reg + 3'd1;

        // shortest-form check on the completed value
        case (total_reg)
            TRAIL_ONE:   bad = (pv_shift < MIN_TWO);
            TRAIL_TWO:   bad = (pv_shift < MIN_THREE);
            TRAIL_THREE: bad = (pv_shift < MIN_FOUR);
            default:     bad = 1'b1;
        endcase

        // result of a byte taken as a lead, if it gives one
        lead_emits     = (lead.kind != KIND_LEAD) || in_eob;
        lead_rec.value = (lead.kind == KIND_ASCII) ? {13'd0, in_byte} : REPL_CHAR;
        lead_rec.used  = 3'd1;
        lead_rec.repl  = (lead.kind != KIND_ASCII);
        lead_rec.last  = 1'b1;

        pv_next    = pv_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        taken_next = taken_reg;
        push       = '0;

        if (accept) begin
            if (rem_reg == TRAIL_NONE) begin
                if (lead_emits) begin
                    push.valid0 = 1'b1;
                    push.rec0   = lead_rec;
                    pv_next     = '0;
                    rem_next    = TRAIL_NONE;
                    total_next  = TRAIL_NONE;
                    taken_next  = 3'd0;
                end else begin
                    pv_next    = {16'd0, lead.bits};
                    rem_next   = lead.trail;
                    total_next = lead.trail;
                    taken_next = 3'd1;
                end
            end else if (is_cont) begin
                if (rem_reg == TRAIL_ONE || in_eob) begin
                    // sequence completes or is cut short by the end flag
                    push.valid0     = 1'b1;
                    push.rec0.used  = taken_inc;
                    push.rec0.last  = 1'b1;
                    push.rec0.repl  = (rem_reg != TRAIL_ONE) || bad;
                    push.rec0.value = push.rec0.repl ? REPL_CHAR : pv_shift;
                    pv_next         = '0;
                    rem_next        = TRAIL_NONE;
                    total_next      = TRAIL_NONE;
                    taken_next      = 3'd0;
                end else begin
                    pv_next    = pv_shift;
                    rem_next   = rem_reg - 3'd1;
                    taken_next = taken_inc;
                end
            end else begin
                // broken sequence, then reprocess the byte as a lead
                push.valid0     = 1'b1;
                push.rec0.value = REPL_CHAR;
                push.rec0.used  = taken_reg;
                push.rec0.repl  = 1'b1;
                push.rec0.last  = !lead_emits;
                if (lead_emits) begin
                    push.valid1 = 1'b1;
                    push.rec1   = lead_rec;
                    pv_next     = '0;
                    rem_next    = TRAIL_NONE;
                    total_next  = TRAIL_NONE;
                    taken_next  = 3'd0;
                end else begin
                    pv_next    = {16'd0, lead.bits};
                    rem_next   = lead.trail;
                    total_next = lead.trail;
                    taken_next = 3'd1;
                end
            end
        end
    end

    // Hold the sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= '0;
            rem_reg   <= TRAIL_NONE;
            total_reg <= TRAIL_NONE;
            taken_reg <= 3'd0;
        end else begin
            pv_reg    <= pv_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
            taken_reg <= taken_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg != TRAIL_NONE) |->
            ({1'b0, taken_reg} + {1'b0, rem_reg} == {1'b0, total_reg} + 4'd1))
        else $error("taken and remaining counts disagree with the lead");
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= TRAIL_FIVE)
        else $error("trail count beyond a six-byte form");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/u2c_queue.sv
// Result queue between front and back: two pushes and one pop per cycle.
`default_nettype none

module u2c_queue
    import u2c_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire u2c_push_t push,
    input  wire logic      pop,
    output logic           space_ok,
    output logic           head_valid,
    output u2c_rec_t       head
);

    u2c_rec_t         slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       push_n;

    // Room for the worst case of two results from one byte
    assign space_ok   = (count_reg <= CNT_W'(Q_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        push_n      = {1'b0, push.valid0} + {1'b0, push.valid1};
        wr_ptr_next = wr_ptr_reg + Q_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    // Store pushed records
    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            slot_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.valid1) begin
            slot_reg[wr_ptr_reg + Q_AW'(1)] <= push.rec1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty result queue");
    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid1 |-> (push.valid0 && !push.rec0.last && push.rec1.last))
        else $error("second record pushed without a leading broken-sequence record");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/u2c_back.sv
// Back end: drains the queue into the output register and packs the result.
`default_nettype none

module u2c_back
    import u2c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  wire u2c_rec_t    head,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic     out_valid_reg, out_valid_next;
    u2c_rec_t out_rec_reg;

    // Load a new result when the register is empty or being taken
    assign pop            = head_valid && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = pop || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_rec_reg <= head;
        end
    end

    // Substitute the replacement character and pack the fields
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_rec_reg.repl, out_rec_reg.used,
                            out_rec_reg.repl ? REPL_CHAR : out_rec_reg.value};
    assign m_axis_tlast  = out_rec_reg.last;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_codepoint_decoder.sv
// Top level of the UTF-8 to code point decoder.
//
//  Channel  Direction  tdata (low bit up)                         tlast
//  s_axis   in         in_byte[7:0]                               end_of_buffer
//  m_axis   out        code_point[20:0], bytes_used[23:21],       last_of_run
//                      is_replacement[24], zero[31:25]
//
// One byte is accepted per cycle; a result passes through the result queue
// and then the output register. A broken sequence gives two results from one
// byte, drained one per cycle while the output is taken, through a four-entry
// result queue; the input stalls while fewer than two queue entries are free.
// Reset (synchronous, active low) leaves no sequence pending and the queue empty.
`default_nettype none

module utf8_to_codepoint_decoder
    import u2c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // code_point, bytes_used, is_replacement
    output logic             m_axis_tlast    // last_of_run
);

    u2c_push_t push;
    logic      space_ok;
    logic      head_valid;
    u2c_rec_t  head;
    logic      pop;

    assign s_axis_tready = space_ok;

    // Decode bytes into result records
    u2c_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (space_ok),
        .in_byte  (s_axis_tdata),
        .in_eob   (s_axis_tlast),
        .push     (push)
    );

    // Buffer records between the two sides
    u2c_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head)
    );

    // Present records on the result channel
    u2c_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
